### rtl/assert_macros.svh
// Assertion macros used by the graph walk datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define GBT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition never holds outside of reset.
`define GBT_ASSERT_NEVER(name, cond, msg) \
   `GBT_ASSERT(name, !(cond), msg)

`endif

### rtl/gbt_pkg.sv
// Shared constants, codes and control types of the graph walk block.
package gbt_pkg;

   // Sizes of the graph storage.
   localparam int MAX_VERTICES = 32;
   localparam int MAX_DEGREE   = 32;
   localparam int RESULT_CAP   = 32;

   localparam int VERTEX_W  = $clog2(MAX_VERTICES);
   localparam int DIDX_W    = $clog2(MAX_DEGREE);
   localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
   localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int RCNT_W    = $clog2(RESULT_CAP + 1);
   localparam int ADDR_W    = VERTEX_W + DIDX_W;
   localparam int MEM_DEPTH = MAX_VERTICES * MAX_DEGREE;

   // Field widths of the channel words.
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int NV_W     = 6;

   localparam logic [NV_W-1:0] NV_RESET = 6'd26;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_BFS      = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_DFS      = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                take_req;
      logic                do_add;
      logic                do_clear;
      logic                walk_init;
      logic                next_bfs;
      logic                scan_start_dfs;
      logic                scan_run;
      logic                bfs_check;
      logic                dfs_push;
      logic                dfs_pop;
      logic                emit;
      logic                emit_pend;
      logic                emit_last;
      logic [STATUS_W-1:0] emit_status;
   } gbt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                bad_edge;
      logic                list_full;
      logic                bad_start;
      logic                out_free;
      logic                loop_more;
      logic                pend_v;
      logic                scan_done;
      logic                chk_fresh;
      logic                can_push;
   } gbt_stat_type;

endpackage

### rtl/gbt_if.sv
// Channel interfaces of the graph walk block: request, response and register write.

interface gbt_req_if;
   logic                          valid;
   logic                          ready;
   logic [gbt_pkg::OPCODE_W-1:0]  opcode;
   logic [gbt_pkg::VERTEX_W-1:0]  source;
   logic [gbt_pkg::VERTEX_W-1:0]  target;

   modport mp_source (output valid, output opcode, output source, output target,
                      input ready);
   modport mp_sink (input valid, input opcode, input source, input target,
                    output ready);
endinterface

interface gbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gbt_pkg::VERTEX_W-1:0]  vertex;
   logic [gbt_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport mp_source (output valid, output vertex, output status, output last,
                      input ready);
   modport mp_sink (input valid, input vertex, input status, input last,
                    output ready);
endinterface

interface gbt_csr_if;
   logic                      valid;
   logic                      ready;
   logic [gbt_pkg::NV_W-1:0]  data;

   modport mp_source (output valid, output data, input ready);
   modport mp_sink (input valid, input data, output ready);
endinterface

### rtl/gbt_datapath.sv
// Datapath of the graph walk: neighbor memory, degrees, work list and result register.
`include "assert_macros.svh"

module gbt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gbt_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_source,
   input  logic [gbt_pkg::VERTEX_W-1:0]  req_target,
   input  logic                          csr_write,
   input  logic [gbt_pkg::NV_W-1:0]      csr_data,
   input  gbt_pkg::gbt_cmd_type          cmd,
   output gbt_pkg::gbt_stat_type         stat,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [gbt_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic [gbt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);

   // Vertex count register and the latched request word.
   logic [gbt_pkg::NV_W-1:0]      nv_raw_ff;
   logic [gbt_pkg::NV_W-1:0]      nv;
   logic [gbt_pkg::OPCODE_W-1:0]  op_ff;
   logic [gbt_pkg::VERTEX_W-1:0]  src_ff;
   logic [gbt_pkg::VERTEX_W-1:0]  dst_ff;

   // Graph storage.
   logic [gbt_pkg::VERTEX_W-1:0]  nbr_mem [0:gbt_pkg::MEM_DEPTH-1];
   logic [gbt_pkg::DEG_W-1:0]     deg_ff [0:gbt_pkg::MAX_VERTICES-1];

   // Walk state.
   logic [gbt_pkg::MAX_VERTICES-1:0] vis_ff, vis_in;
   logic [gbt_pkg::VERTEX_W-1:0]  list_ff [0:gbt_pkg::MAX_VERTICES-1];
   logic [gbt_pkg::DEG_W-1:0]     cursor_ff [0:gbt_pkg::MAX_VERTICES-1];
   logic [gbt_pkg::CNT_W-1:0]     head_ff, head_in;
   logic [gbt_pkg::CNT_W-1:0]     tail_ff, tail_in;
   logic [gbt_pkg::CNT_W-1:0]     tail_m1;
   logic [gbt_pkg::RCNT_W-1:0]    n_ff, n_in;
   logic [gbt_pkg::VERTEX_W-1:0]  pend_ff, pend_in;
   logic                          pend_v_ff, pend_v_in;

   // Neighbor scan pipeline.
   logic [gbt_pkg::VERTEX_W-1:0]  scan_vert_ff, scan_vert_in;
   logic [gbt_pkg::DEG_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [gbt_pkg::DEG_W-1:0]     end_ff, end_in;
   logic                          chk_v_ff, chk_v_in;
   logic [gbt_pkg::DIDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [gbt_pkg::VERTEX_W-1:0]  rd_data_ff;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gbt_pkg::VERTEX_W-1:0]  rsp_vertex_ff;
   logic [gbt_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                          rsp_last_ff;

   logic [gbt_pkg::VERTEX_W-1:0]  head_idx, top_idx, tail_idx, next_vert;
   logic [gbt_pkg::DEG_W-1:0]     start_idx;
   logic [gbt_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
   logic                          issue, fresh, can_push, out_free, bfs_push;

   // Vertex count in use, clamped to the storage size.
   assign nv = (nv_raw_ff > gbt_pkg::NV_W'(gbt_pkg::MAX_VERTICES))
             ? gbt_pkg::NV_W'(gbt_pkg::MAX_VERTICES) : nv_raw_ff;

   // Work list positions.
   assign tail_m1  = tail_ff - gbt_pkg::CNT_W'(1);
   assign head_idx = head_ff[gbt_pkg::VERTEX_W-1:0];
   assign top_idx  = tail_m1[gbt_pkg::VERTEX_W-1:0];
   assign tail_idx = tail_ff[gbt_pkg::VERTEX_W-1:0];

   // A breadth-first step starts at the queue head, a depth-first step at the stack top.
   assign next_vert = cmd.next_bfs ? list_ff[head_idx] : list_ff[top_idx];
   assign start_idx = cmd.next_bfs ? '0 : cursor_ff[top_idx];

   // Neighbor memory addresses.
   assign wr_addr = {src_ff, deg_ff[src_ff][gbt_pkg::DIDX_W-1:0]};
   assign rd_addr = {scan_vert_ff, rd_idx_ff[gbt_pkg::DIDX_W-1:0]};
   assign issue   = cmd.scan_run && (rd_idx_ff < end_ff);

   // A checked neighbor is fresh when it is in range and not yet visited.
   assign fresh    = chk_v_ff && (gbt_pkg::NV_W'(rd_data_ff) < nv) && !vis_ff[rd_data_ff];
   assign can_push = tail_ff < gbt_pkg::CNT_W'(gbt_pkg::MAX_VERTICES);
   assign bfs_push = cmd.bfs_check && fresh && can_push;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status toward the controller.
   always_comb begin
      stat.op        = op_ff;
      stat.bad_edge  = (gbt_pkg::NV_W'(src_ff) >= nv) || (gbt_pkg::NV_W'(dst_ff) >= nv);
      stat.list_full = deg_ff[src_ff] >= gbt_pkg::DEG_W'(gbt_pkg::MAX_DEGREE);
      stat.bad_start = gbt_pkg::NV_W'(src_ff) >= nv;
      stat.out_free  = out_free;
      if (op_ff == gbt_pkg::OP_DFS) begin
         stat.loop_more = (tail_ff != '0) && (n_ff < gbt_pkg::RCNT_W'(gbt_pkg::RESULT_CAP));
      end else begin
         stat.loop_more = (head_ff < tail_ff) && (n_ff < gbt_pkg::RCNT_W'(gbt_pkg::RESULT_CAP));
      end
      stat.pend_v    = pend_v_ff;
      stat.scan_done = !chk_v_ff && !(rd_idx_ff < end_ff);
      stat.chk_fresh = fresh;
      stat.can_push  = can_push;
   end

   // Next values of the walk and scan registers.
   always_comb begin
      vis_in       = vis_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      scan_vert_in = scan_vert_ff;
      rd_idx_in    = rd_idx_ff;
      end_in       = end_ff;
      chk_v_in     = issue;
      chk_idx_in   = issue ? rd_idx_ff[gbt_pkg::DIDX_W-1:0] : chk_idx_ff;

      if (cmd.walk_init) begin
         vis_in         = '0;
         vis_in[src_ff] = 1'b1;
         head_in        = '0;
         tail_in        = gbt_pkg::CNT_W'(1);
         pend_in        = src_ff;
         pend_v_in      = (op_ff == gbt_pkg::OP_DFS);
         n_in           = (op_ff == gbt_pkg::OP_DFS) ? gbt_pkg::RCNT_W'(1) : '0;
      end

      // Dequeue the next vertex; it becomes the pending result.
      if (cmd.next_bfs) begin
         head_in   = head_ff + gbt_pkg::CNT_W'(1);
         n_in      = n_ff + gbt_pkg::RCNT_W'(1);
         pend_in   = next_vert;
         pend_v_in = 1'b1;
      end

      // Load the scan of one neighbor list.
      if (cmd.next_bfs || cmd.scan_start_dfs) begin
         scan_vert_in = next_vert;
         rd_idx_in    = start_idx;
         end_in       = deg_ff[next_vert];
         chk_v_in     = 1'b0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + gbt_pkg::DEG_W'(1);
      end

      if (bfs_push) begin
         vis_in[rd_data_ff] = 1'b1;
         tail_in            = tail_ff + gbt_pkg::CNT_W'(1);
      end

      if (cmd.dfs_push) begin
         vis_in[rd_data_ff] = 1'b1;
         tail_in            = tail_ff + gbt_pkg::CNT_W'(1);
         n_in               = n_ff + gbt_pkg::RCNT_W'(1);
         pend_in            = rd_data_ff;
      end

      if (cmd.dfs_pop) begin
         tail_in = tail_m1;
      end
   end

   // The result register frees when the sink takes the word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_raw_ff    <= gbt_pkg::NV_RESET;
         vis_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         n_ff         <= '0;
         pend_v_ff    <= 1'b0;
         chk_v_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            nv_raw_ff <= csr_data;
         end
         vis_ff       <= vis_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         n_ff         <= n_in;
         pend_v_ff    <= pend_v_in;
         chk_v_ff     <= chk_v_in;
         rd_idx_ff    <= rd_idx_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Degree counts: cleared by reset and by the clear operation.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         for (int i = 0; i < gbt_pkg::MAX_VERTICES; i++) begin
            deg_ff[i] <= '0;
         end
      end else if (cmd.do_add) begin
         deg_ff[src_ff] <= deg_ff[src_ff] + gbt_pkg::DEG_W'(1);
      end
   end

   // Neighbor memory with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.do_add) begin
         nbr_mem[wr_addr] <= dst_ff;
      end
      if (issue) begin
         rd_data_ff <= nbr_mem[rd_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff  <= req_opcode;
         src_ff <= req_source;
         dst_ff <= req_target;
      end
      pend_ff      <= pend_in;
      scan_vert_ff <= scan_vert_in;
      chk_idx_ff   <= chk_idx_in;
      if (cmd.emit) begin
         rsp_vertex_ff <= cmd.emit_pend ? pend_ff : '0;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   // Work list and per-entry scan cursors.
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         list_ff[0]   <= src_ff;
         cursor_ff[0] <= '0;
      end
      if (bfs_push) begin
         list_ff[tail_idx] <= rd_data_ff;
      end
      if (cmd.dfs_push) begin
         list_ff[tail_idx]   <= rd_data_ff;
         cursor_ff[tail_idx] <= '0;
         cursor_ff[top_idx]  <= gbt_pkg::DEG_W'(chk_idx_ff) + gbt_pkg::DEG_W'(1);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // A new word is loaded only into a free result register.
   `GBT_ASSERT(a_emit_free, cmd.emit |-> out_free, "result word overwritten")
   // A pending vertex is emitted only when one is held.
   `GBT_ASSERT(a_emit_pend, (cmd.emit && cmd.emit_pend) |-> pend_v_ff, "no pending vertex")
   // An edge is stored only into a list with room left.
   `GBT_ASSERT(a_add_room, cmd.do_add |-> !stat.list_full, "edge stored into full list")
   // The queue head never passes the tail.
   `GBT_ASSERT_NEVER(a_head_tail, head_ff > tail_ff, "queue head passed tail")

endmodule

### rtl/gbt_ctrl.sv
// Controller state machine that sequences edge updates and graph walks.

module gbt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gbt_pkg::gbt_stat_type  stat,
   output gbt_pkg::gbt_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_NEXT   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_PUSH   = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       is_dfs;

   assign req_ready = (state_ff == S_IDLE);
   assign is_dfs    = (stat.op == gbt_pkg::OP_DFS);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_DECODE;
            end
         end

         S_DECODE: begin
            unique case (stat.op)
               gbt_pkg::OP_ADD_EDGE: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (stat.bad_edge) begin
                        cmd.emit_status = gbt_pkg::ST_RANGE;
                     end else if (stat.list_full) begin
                        cmd.emit_status = gbt_pkg::ST_FULL;
                     end else begin
                        cmd.emit_status = gbt_pkg::ST_OK;
                        cmd.do_add      = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               gbt_pkg::OP_CLEAR: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = gbt_pkg::ST_OK;
                     cmd.do_clear    = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               gbt_pkg::OP_BFS, gbt_pkg::OP_DFS: begin
                  if (!stat.bad_start) begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_NEXT;
                  end else if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = gbt_pkg::ST_RANGE;
                     state_in        = S_IDLE;
                  end
               end
            endcase
         end

         // Pick the next vertex to expand, or finish the walk.
         S_NEXT: begin
            if (!stat.loop_more) begin
               state_in = S_FINAL;
            end else if (is_dfs) begin
               cmd.scan_start_dfs = 1'b1;
               state_in           = S_SCAN;
            end else if (!stat.pend_v || stat.out_free) begin
               cmd.next_bfs    = 1'b1;
               cmd.emit        = stat.pend_v;
               cmd.emit_pend   = 1'b1;
               cmd.emit_status = gbt_pkg::ST_OK;
               state_in        = S_SCAN;
            end
         end

         // Read the neighbor list, one entry a cycle until a depth-first scan finds a fresh neighbor.
         S_SCAN: begin
            if (is_dfs) begin
               if (stat.chk_fresh) begin
                  state_in = S_PUSH;
               end else if (stat.scan_done) begin
                  cmd.dfs_pop = 1'b1;
                  state_in    = S_NEXT;
               end else begin
                  cmd.scan_run = 1'b1;
               end
            end else begin
               cmd.scan_run  = 1'b1;
               cmd.bfs_check = 1'b1;
               if (stat.scan_done) begin
                  state_in = S_NEXT;
               end
            end
         end

         // Push the found neighbor and emit the vertex before it, or pop when the stack is full.
         S_PUSH: begin
            if (!stat.can_push) begin
               cmd.dfs_pop = 1'b1;
               state_in    = S_NEXT;
            end else if (stat.out_free) begin
               cmd.dfs_push    = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_pend   = 1'b1;
               cmd.emit_status = gbt_pkg::ST_OK;
               state_in        = S_NEXT;
            end
         end

         // The held vertex is the final word of the walk.
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_pend   = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = gbt_pkg::ST_OK;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/graph_bfs_dfs_traversal.sv
// Graph walk engine: breadth-first and depth-first search over stored neighbor lists.
//
// Add-edge and clear requests return one word. A walk returns the visit order, up
// to 32 words, the final one flagged by last. All neighbor entries come from one
// 1024-entry memory with a single registered read port, read one entry per cycle
// while a list is scanned. A breadth-first walk reads each stored neighbor entry at
// most once. A depth-first walk keeps a scan cursor for each stack entry, so every
// list entry is read at most once as well. A new request is taken once the previous
// one has queued its final word; the result register holds that word while the next
// request starts.

module graph_bfs_dfs_traversal (
   input logic              clock,
   input logic              reset,
   gbt_req_if.mp_sink       req_port,
   gbt_rsp_if.mp_source     rsp_port,
   gbt_csr_if.mp_sink       csr_port
);

   gbt_pkg::gbt_cmd_type  cmd;
   gbt_pkg::gbt_stat_type stat;
   logic                  csr_write;

   // The count register is always ready for a write.
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;

   // Sequencing.
   gbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and result register.
   gbt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_opcode (req_port.opcode),
      .req_source (req_port.source),
      .req_target (req_port.target),
      .csr_write  (csr_write),
      .csr_data   (csr_port.data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_vertex (rsp_port.vertex),
      .rsp_status (rsp_port.status),
      .rsp_last   (rsp_port.last)
   );

endmodule

### sim/tb_graph_bfs_dfs_traversal.sv
// Testbench of the graph walk engine: directed and random requests checked against a predictor.
module tb_graph_bfs_dfs_traversal;

   localparam int RAND_ITEMS   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 8000;
   localparam int SETTLE_WAIT  = 8;
   localparam int DRAIN_CYCLES = 64;
   localparam bit FIXED        = 1'b1;
   localparam bit PREDICTED    = 1'b0;

   typedef logic [gbt_pkg::VERTEX_W-1:0] vertex_type;

   // One response word as the block returns it.
   typedef struct packed {
      vertex_type                   vertex;
      logic [gbt_pkg::STATUS_W-1:0] status;
      logic                         last;
   } visit_word_type;

   // One row of the directed stimulus, with an optional typed-in single word.
   typedef struct {
      logic [gbt_pkg::OPCODE_W-1:0] opcode;
      vertex_type                   source;
      vertex_type                   target;
      bit                           fixed_exp;
      vertex_type                   exp_vertex;
      logic [gbt_pkg::STATUS_W-1:0] exp_status;
   } stim_row_type;

   logic clock;
   logic reset;

   gbt_req_if req_bus ();
   gbt_rsp_if rsp_bus ();
   gbt_csr_if csr_bus ();

   graph_bfs_dfs_traversal dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Predictor copy of the graph and the vertex count register.
   vertex_type               adj_list [gbt_pkg::MAX_VERTICES][gbt_pkg::MAX_DEGREE];
   int                       adj_degree [gbt_pkg::MAX_VERTICES];
   logic [gbt_pkg::NV_W-1:0] vertex_limit;

   visit_word_type visit_words_due [$];
   visit_word_type due_word;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned gap_max = 3;
   int unsigned stall_pct = 25;
   bit          hold_off_req = 1'b0;

   always #1 clock = ~clock;

   // Vertex count in effect: values above the table size act as the table size.
   function automatic int active_vertices();
      return (vertex_limit > gbt_pkg::MAX_VERTICES) ? gbt_pkg::MAX_VERTICES
                                                     : int'(vertex_limit);
   endfunction

   function automatic vertex_type pick_vertex(input int count);
      if (count == 0)
         return vertex_type'($urandom_range(0, gbt_pkg::MAX_VERTICES - 1));
      return vertex_type'($urandom_range(0, count - 1));
   endfunction

   function automatic stim_row_type make_row(input logic [gbt_pkg::OPCODE_W-1:0] op,
                                             input int src, input int dst,
                                             input bit fixed_exp, input int exp_vertex,
                                             input logic [gbt_pkg::STATUS_W-1:0] exp_status);
      stim_row_type row;
      row = '{op, vertex_type'(src), vertex_type'(dst), fixed_exp,
              vertex_type'(exp_vertex), exp_status};
      return row;
   endfunction

   // Applies one request to the predicted graph and returns the words it must produce.
   function automatic void compute_visit_order(input logic [gbt_pkg::OPCODE_W-1:0] op,
                                               input vertex_type src, input vertex_type dst,
                                               output visit_word_type words [$]);
      int         nv;
      int         head;
      int         tail;
      int         top;
      bit         found;
      vertex_type fresh;
      vertex_type cur;
      bit         seen [gbt_pkg::MAX_VERTICES];
      vertex_type work [gbt_pkg::MAX_VERTICES];
      words = {};
      nv = active_vertices();
      if (op == gbt_pkg::OP_ADD_EDGE) begin
         if (src >= nv || dst >= nv) begin
            words.push_back(visit_word_type'{'0, gbt_pkg::ST_RANGE, 1'b0});
         end else if (adj_degree[src] >= gbt_pkg::MAX_DEGREE) begin
            words.push_back(visit_word_type'{'0, gbt_pkg::ST_FULL, 1'b0});
         end else begin
            adj_list[src][adj_degree[src]] = dst;
            adj_degree[src]++;
            words.push_back(visit_word_type'{'0, gbt_pkg::ST_OK, 1'b0});
         end
      end else if (op == gbt_pkg::OP_CLEAR) begin
         foreach (adj_degree[v]) adj_degree[v] = 0;
         words.push_back(visit_word_type'{'0, gbt_pkg::ST_OK, 1'b0});
      end else if (src >= nv) begin
         words.push_back(visit_word_type'{'0, gbt_pkg::ST_RANGE, 1'b0});
      end else begin
         foreach (seen[v]) seen[v] = 1'b0;
         seen[src] = 1'b1;
         work[0] = src;
         head = 0;
         tail = 1;
         if (op == gbt_pkg::OP_DFS) begin
            // Depth-first: extend from the top of the stack, pop when it is exhausted.
            words.push_back(visit_word_type'{src, gbt_pkg::ST_OK, 1'b0});
            while (tail > 0 && words.size() < gbt_pkg::RESULT_CAP) begin
               top = int'(work[tail-1]);
               found = 1'b0;
               for (int i = 0; i < adj_degree[top] && !found; i++) begin
                  if (adj_list[top][i] < nv && !seen[adj_list[top][i]]) begin
                     fresh = adj_list[top][i];
                     found = 1'b1;
                  end
               end
               if (found && tail < gbt_pkg::MAX_VERTICES) begin
                  seen[fresh] = 1'b1;
                  work[tail] = fresh;
                  tail++;
                  words.push_back(visit_word_type'{fresh, gbt_pkg::ST_OK, 1'b0});
               end else begin
                  tail--;
               end
            end
         end else begin
            // Breadth-first: emit the queue head, then enqueue its fresh neighbors.
            while (head < tail && words.size() < gbt_pkg::RESULT_CAP) begin
               cur = work[head];
               head++;
               words.push_back(visit_word_type'{cur, gbt_pkg::ST_OK, 1'b0});
               for (int i = 0; i < adj_degree[cur]; i++) begin
                  if (adj_list[cur][i] < nv && !seen[adj_list[cur][i]] &&
                      tail < gbt_pkg::MAX_VERTICES) begin
                     seen[adj_list[cur][i]] = 1'b1;
                     work[tail] = adj_list[cur][i];
                     tail++;
                  end
               end
            end
         end
      end
      words[words.size()-1].last = 1'b1;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Offers one request word in bursts with random gaps and records what it must produce.
   task automatic send_request(input logic [gbt_pkg::OPCODE_W-1:0] op, input vertex_type src,
                               input vertex_type dst, input bit fixed_exp = PREDICTED,
                               input vertex_type exp_vertex = '0,
                               input logic [gbt_pkg::STATUS_W-1:0] exp_status =
                                  gbt_pkg::ST_OK);
      int unsigned gap;
      visit_word_type words [$];
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.source <= src;
      req_bus.target <= dst;
      do @(posedge clock); while (!req_bus.ready);
      compute_visit_order(op, src, dst, words);
      if (fixed_exp)
         visit_words_due.push_back(visit_word_type'{exp_vertex, exp_status, 1'b1});
      else
         foreach (words[k]) visit_words_due.push_back(words[k]);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Writes the vertex count once every outstanding word has come back.
   task automatic write_vertex_limit(input logic [gbt_pkg::NV_W-1:0] value);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (visit_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      vertex_limit = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Receiver pacing: random stall runs, plus one long hold-off when requested.
   initial begin : rsp_pacing
      int unsigned stall_run;
      stall_run = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         if (stall_run != 0) begin
            stall_run--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_run = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (visit_words_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected word vertex=%0d status=%0d last=%0d",
                                    rsp_bus.vertex, rsp_bus.status, rsp_bus.last));
         end else begin
            due_word = visit_words_due.pop_front();
            if (rsp_bus.vertex !== due_word.vertex)
               flag_mismatch($sformatf("vertex %0d, want %0d", rsp_bus.vertex, due_word.vertex));
            if (rsp_bus.status !== due_word.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, due_word.status));
            if (rsp_bus.last !== due_word.last)
               flag_mismatch($sformatf("last %0d, want %0d", rsp_bus.last, due_word.last));
         end
      end
   end

   // Watchdog: end the run when no channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("tb_graph_bfs_dfs_traversal NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type             directed_rows [$];
      int                       nv;
      int unsigned              roll;
      int unsigned              rand_base;
      int unsigned              phase;
      logic [gbt_pkg::NV_W-1:0] limit;

      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.opcode = gbt_pkg::OP_ADD_EDGE;
      req_bus.source = '0;
      req_bus.target = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
      vertex_limit   = gbt_pkg::NV_RESET;
      foreach (adj_degree[v]) adj_degree[v] = 0;

      // Directed part on the empty graph after reset, vertex count at its reset value.
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 0, 0, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_DFS, 25, 31, FIXED, 25, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 26, 0, FIXED, 0, gbt_pkg::ST_RANGE));
      directed_rows.push_back(make_row(gbt_pkg::OP_DFS, 31, 0, FIXED, 0, gbt_pkg::ST_RANGE));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 31, 0, FIXED, 0,
                                       gbt_pkg::ST_RANGE));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 0, 31, FIXED, 0,
                                       gbt_pkg::ST_RANGE));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 0, 1, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 0, 2, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 1, 3, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 2, 3, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 3, 0, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 2, 4, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 0, 0, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 4, 25, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 25, 26, FIXED, 0,
                                       gbt_pkg::ST_RANGE));
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 0, 0, PREDICTED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_DFS, 0, 0, PREDICTED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_DFS, 3, 0, PREDICTED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 25, 0, PREDICTED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_CLEAR, 0, 0, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 0, 0, FIXED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_ADD_EDGE, 25, 24, FIXED, 0,
                                       gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_DFS, 25, 0, PREDICTED, 0, gbt_pkg::ST_OK));
      directed_rows.push_back(make_row(gbt_pkg::OP_BFS, 24, 0, PREDICTED, 0, gbt_pkg::ST_OK));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].opcode, directed_rows[i].source, directed_rows[i].target,
                      directed_rows[i].fixed_exp, directed_rows[i].exp_vertex,
                      directed_rows[i].exp_status);

      // A chain through all 32 vertices gives walks that stop at the result cap.
      write_vertex_limit(6'd32);
      send_request(gbt_pkg::OP_CLEAR, '0, '0);
      for (int v = 0; v < gbt_pkg::MAX_VERTICES - 1; v++)
         send_request(gbt_pkg::OP_ADD_EDGE, vertex_type'(v), vertex_type'(v + 1));
      send_request(gbt_pkg::OP_BFS, '0, '0);
      send_request(gbt_pkg::OP_DFS, '0, '0);

      // Fill one list past its capacity so the last edges are dropped.
      repeat (gbt_pkg::MAX_DEGREE + 2)
         send_request(gbt_pkg::OP_ADD_EDGE, vertex_type'(5),
                      pick_vertex(gbt_pkg::MAX_VERTICES));
      send_request(gbt_pkg::OP_BFS, vertex_type'(5), '0);
      send_request(gbt_pkg::OP_DFS, vertex_type'(5), '0);

      // A count above the table size behaves as the full table.
      write_vertex_limit(6'd63);
      send_request(gbt_pkg::OP_BFS, '0, '0);
      send_request(gbt_pkg::OP_ADD_EDGE, vertex_type'(31), '0);
      send_request(gbt_pkg::OP_DFS, vertex_type'(31), '0);

      // Lowering the count leaves stale neighbors that the walks must skip.
      write_vertex_limit(6'd4);
      send_request(gbt_pkg::OP_BFS, '0, '0);
      send_request(gbt_pkg::OP_DFS, vertex_type'(2), '0);
      send_request(gbt_pkg::OP_DFS, vertex_type'(5), '0);
      send_request(gbt_pkg::OP_ADD_EDGE, vertex_type'(3), vertex_type'(4));

      // Counts of one and zero leave at most vertex 0 valid.
      write_vertex_limit(6'd1);
      send_request(gbt_pkg::OP_DFS, '0, '0);
      send_request(gbt_pkg::OP_ADD_EDGE, '0, '0);
      send_request(gbt_pkg::OP_BFS, vertex_type'(1), '0);
      write_vertex_limit(6'd0);
      send_request(gbt_pkg::OP_BFS, '0, '0);
      send_request(gbt_pkg::OP_ADD_EDGE, '0, '0);
      send_request(gbt_pkg::OP_CLEAR, '0, '0);

      // Random phases: build a graph, then mix walks, edges, clears and noise.
      rand_base = items_sent;
      phase = 0;
      while (items_sent - rand_base < RAND_ITEMS) begin
         case ($urandom_range(0, 6))
            0: limit = 6'd2;
            1: limit = 6'd32;
            2: limit = 6'd63;
            3: limit = gbt_pkg::NV_W'($urandom_range(0, 63));
            default: limit = gbt_pkg::NV_W'($urandom_range(2, 32));
         endcase
         write_vertex_limit(limit);
         nv = active_vertices();
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         stall_pct = (gap_max == 0) ? 0 : $urandom_range(5, 60);
         if (phase == 1) begin
            gap_max = 1;
            hold_off_req = 1'b1;
         end
         if ($urandom_range(0, 1) == 1)
            send_request(gbt_pkg::OP_CLEAR, pick_vertex(gbt_pkg::MAX_VERTICES),
                         pick_vertex(gbt_pkg::MAX_VERTICES));
         repeat ($urandom_range(0, (3 * nv > 48) ? 48 : 3 * nv))
            send_request(gbt_pkg::OP_ADD_EDGE, pick_vertex(nv), pick_vertex(nv));
         repeat ($urandom_range(10, 30)) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
               send_request(($urandom_range(0, 1) == 1) ? gbt_pkg::OP_DFS : gbt_pkg::OP_BFS,
                            pick_vertex(nv), pick_vertex(gbt_pkg::MAX_VERTICES));
            else if (roll < 70)
               send_request(gbt_pkg::OP_ADD_EDGE, pick_vertex(nv), pick_vertex(nv));
            else if (roll < 80)
               send_request(gbt_pkg::OP_ADD_EDGE, pick_vertex(gbt_pkg::MAX_VERTICES),
                            pick_vertex(gbt_pkg::MAX_VERTICES));
            else if (roll < 90)
               send_request(($urandom_range(0, 1) == 1) ? gbt_pkg::OP_DFS : gbt_pkg::OP_BFS,
                            pick_vertex(gbt_pkg::MAX_VERTICES),
                            pick_vertex(gbt_pkg::MAX_VERTICES));
            else if (roll < 93)
               send_request(gbt_pkg::OP_CLEAR, pick_vertex(gbt_pkg::MAX_VERTICES),
                            pick_vertex(gbt_pkg::MAX_VERTICES));
            else
               send_request(gbt_pkg::OPCODE_W'($urandom_range(0, 3)),
                            pick_vertex(gbt_pkg::MAX_VERTICES),
                            pick_vertex(gbt_pkg::MAX_VERTICES));
         end
         phase++;
      end

      // Let the last words drain, then give the verdict.
      req_bus.valid <= 1'b0;
      while (visit_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_graph_bfs_dfs_traversal OK");
      else
         $display("tb_graph_bfs_dfs_traversal NOT OK");
      $finish;
   end

endmodule
